/* hdl/scw_pkg.sv */
package scw_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 18;

  localparam int GAIN_W = 18;
  localparam int THR_W  = 16;

  localparam logic [CFG_AW-1:0] REG_PRE_GAIN  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_POST_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] PRE_GAIN_RST  = 18'd131072;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd32768;
  localparam logic [GAIN_W-1:0] POST_GAIN_RST = 18'd49152;

  // quotient bits of the knee ratio and of the shaping divide
  localparam int B_W = 24;
  localparam int Y_W = 32;

endpackage

/* hdl/scw_divpipe.sv */
module scw_divpipe #(
  parameter int DW = 33,
  parameter int QW = 24,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_div,
  input  logic [QW-1:0] in_feed,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] div_r  [QW];
  logic [QW-1:0] feed_r [QW];
  logic [QW-1:0] quot_r [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          pv;
    logic [DW-1:0] prem;
    logic [DW-1:0] pdiv;
    logic [QW-1:0] pfeed;
    logic [QW-1:0] pquot;
    logic [SW-1:0] pside;
    logic [DW:0]   sh;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_rem;
      assign pdiv  = in_div;
      assign pfeed = in_feed;
      assign pquot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[i-1];
      assign prem  = rem_r[i-1];
      assign pdiv  = div_r[i-1];
      assign pfeed = feed_r[i-1];
      assign pquot = quot_r[i-1];
      assign pside = side_r[i-1];
    end

    // one restoring step: shift in a numerator bit, subtract if it fits
    always_comb begin
      sh      = {prem, pfeed[QW-1]};
      ge      = (sh >= {1'b0, pdiv});
      rem_nxt = ge ? DW'(sh - {1'b0, pdiv}) : DW'(sh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        div_r[i]  <= pdiv;
        feed_r[i] <= {pfeed[QW-2:0], 1'b0};
        quot_r[i] <= {pquot[QW-2:0], ge};
        side_r[i] <= pside;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* hdl/soft_clip_waveshaper_core.sv */
// soft clip waveshaper
// in_* carries one signed sample per transaction, out_* the shaped sample,
// both as streams; tdata holds the sample in its low SAMPLE_BITS bits.
// samples at or below the threshold are scaled by pre_gain, samples above
// it are soft clipped through two long divisions; the result is scaled by
// post_gain, rounded and saturated.
// cfg_we writes pre_gain (0), threshold (1) or post_gain (2) from cfg_wdata;
// write only while no transaction is in flight.
// the 24-step and 32-step divide chains compute one quotient bit per stage.
// throughput: one transaction per cycle while the receiver does not stall.
// reset clears all valid bits and loads the default gains and threshold.
// when the receiver stalls with a result waiting, every stage holds and
// in_tready drops; empty stages still fill while the output is idle.
module soft_clip_waveshaper_core #(
  parameter int SAMPLE_BITS = 24,
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [TDW-1:0]             in_tdata,   // sample_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [TDW-1:0]             out_tdata,  // sample_out
  input  logic                       cfg_we,
  input  logic [scw_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [scw_pkg::CFG_DW-1:0] cfg_wdata
);
  import scw_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int YW  = SB + 3;
  localparam int LPW = SB + 19;
  localparam int PW  = YW + 19;
  localparam int RW  = PW - 16;
  localparam int S1W = 1 + LPW + 32;
  localparam int S2W = 1 + LPW;
  localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MINV = RW'(-(64'sd1 <<< (SB - 1)));

  logic [GAIN_W-1:0] pre_r;
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] post_r;
  logic [31:0]       da;
  logic              en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= PRE_GAIN_RST;
      thr_r  <= THRESHOLD_RST;
      post_r <= POST_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PRE_GAIN:  pre_r  <= cfg_wdata[GAIN_W-1:0];
        REG_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        REG_POST_GAIN: post_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign da        = {thr_r, 16'b0};
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // input register
  logic                 v0_r;
  logic signed [SB-1:0] x0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) x0_r <= signed'(in_tdata[SB-1:0]);
  end

  // region select, linear product, knee ratio operands
  logic                  v1_r, soft1_nxt, soft1_r;
  logic signed [LPW-1:0] lin1_nxt, lin1_r;
  logic [31:0]           xa, e1_nxt, e1_r;
  logic [32:0]           den1_nxt, den1_r;

  always_comb begin
    xa        = 32'(x0_r[SB-2:0]) << (33 - SB);
    soft1_nxt = !x0_r[SB-1] && (xa > da);
    lin1_nxt  = LPW'(x0_r * signed'({1'b0, pre_r}));
    e1_nxt    = xa - da;
    den1_nxt  = 33'h1_0000_0000 - {1'b0, da};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      soft1_r <= soft1_nxt;
      lin1_r  <= lin1_nxt;
      e1_r    <= e1_nxt;
      den1_r  <= den1_nxt;
    end
  end

  logic           vb;
  logic [B_W-1:0] b;
  logic [S1W-1:0] sideb;

  scw_divpipe #(.DW(33), .QW(B_W), .SW(S1W)) u_div_knee (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_rem    ({1'b0, e1_r}),
    .in_div    (den1_r),
    .in_feed   ('0),
    .in_side   ({soft1_r, lin1_r, e1_r}),
    .out_valid (vb),
    .out_quot  (b),
    .out_side  (sideb)
  );

  // b squared
  logic           vm_r;
  logic [47:0]    bb_r;
  logic [S1W-1:0] sidem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bb_r    <= b * b;
      sidem_r <= sideb;
    end
  end

  // shaping divisor 1 + b^2
  logic           vq_r;
  logic [24:0]    q_nxt, q_r;
  logic [47:0]    bbr;
  logic [24:0]    remq_r;
  logic [Y_W-1:0] feedq_r;
  logic [S2W-1:0] sideq_r;
  logic [31:0]    em;

  always_comb begin
    bbr   = bb_r + 48'h80_0000;
    q_nxt = 25'h100_0000 + {1'b0, bbr[47:24]};
    em    = sidem_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vq_r <= 1'b0;
    else if (en) vq_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q_nxt;
      remq_r  <= {1'b0, em[31:8]};
      feedq_r <= {em[7:0], 24'b0};
      sideq_r <= sidem_r[S1W-1:32];
    end
  end

  logic           vd;
  logic [Y_W-1:0] yq;
  logic [S2W-1:0] sided;

  scw_divpipe #(.DW(25), .QW(Y_W), .SW(S2W)) u_div_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vq_r),
    .in_rem    (remq_r),
    .in_div    (q_r),
    .in_feed   (feedq_r),
    .in_side   (sideq_r),
    .out_valid (vd),
    .out_quot  (yq),
    .out_side  (sided)
  );

  // shaped value at sample scale
  logic                  vy_r, softy_r;
  logic signed [YW-1:0]  y_nxt, y_r;
  logic [33:0]           ys, ysr;
  logic signed [LPW-1:0] lsum;

  always_comb begin
    ys   = {2'b0, da} + {2'b0, yq};
    ysr  = (ys + (34'd1 << (32 - SB))) >> (33 - SB);
    lsum = signed'(sided[LPW-1:0]) + LPW'(32768);
    if (sided[S2W-1]) y_nxt = signed'(YW'(ysr));
    else y_nxt = YW'(lsum >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vy_r <= 1'b0;
    else if (en) vy_r <= vd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      y_r     <= y_nxt;
      softy_r <= sided[S2W-1];
    end
  end

  // post gain product
  logic                 vp_r;
  logic signed [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else if (en) vp_r <= vy_r;
  end
  always_ff @(posedge clk) begin
    if (en) p_r <= PW'(y_r * signed'({1'b0, post_r}));
  end

  // round, saturate, output register
  logic                 vo_r;
  logic [SB-1:0]        o_nxt, o_r;
  logic signed [PW-1:0] psum;
  logic signed [RW-1:0] r;

  always_comb begin
    psum = p_r + PW'(32768);
    r    = RW'(psum >>> 16);
    if (r > MAXV) o_nxt = MAXV[SB-1:0];
    else if (r < MINV) o_nxt = MINV[SB-1:0];
    else o_nxt = r[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= vp_r;
  end
  always_ff @(posedge clk) begin
    if (en) o_r <= o_nxt;
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = TDW'(o_r);

`ifndef SYNTHESIS
  a_knee_ratio_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && soft1_r |-> ({1'b0, e1_r} < den1_r))
    else $error("knee ratio numerator not below divisor");

  a_shape_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
    vq_r |-> q_r[24])
    else $error("shaping divisor below one");

  a_soft_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    vy_r && softy_r |-> !y_r[YW-1])
    else $error("soft clipped value negative");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    vp_r && !en |=> vp_r)
    else $error("pipeline stage lost during stall");
`endif

endmodule
